>>> rtl/core/bctc_pkg.sv
// Shared types, codes and constants of the block cache tag controller.
package bctc_pkg;

  localparam int ENTRY_COUNT_DEF = 16;
  localparam int DISK_COUNT_DEF  = 8;
  localparam int BLOCK_BITS_DEF  = 24;

  localparam int OP_W    = 3;
  localparam int DISK_W  = 3;
  localparam int SEL_W   = 4;
  localparam int ST_W    = 3;
  localparam int AGE_W   = 32;
  localparam int FLAG_W  = 7;

  localparam logic [OP_W-1:0] OP_PROBE   = 3'd0;
  localparam logic [OP_W-1:0] OP_ACQUIRE = 3'd1;
  localparam logic [OP_W-1:0] OP_RELEASE = 3'd2;
  localparam logic [OP_W-1:0] OP_FLUSH   = 3'd3;
  localparam logic [OP_W-1:0] OP_IODONE  = 3'd4;

  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_NOFREE   = 3'd1;
  localparam logic [ST_W-1:0] ST_LOCKED   = 3'd2;
  localparam logic [ST_W-1:0] ST_IOBUSY   = 3'd3;
  localparam logic [ST_W-1:0] ST_UNLOCKED = 3'd4;
  localparam logic [ST_W-1:0] ST_NODIRTY  = 3'd5;

  localparam logic [FLAG_W-1:0] FL_ULOCK = 7'h01;
  localparam logic [FLAG_W-1:0] FL_RBUSY = 7'h02;
  localparam logic [FLAG_W-1:0] FL_WBUSY = 7'h04;
  localparam logic [FLAG_W-1:0] FL_DIRTY = 7'h08;
  localparam logic [FLAG_W-1:0] FL_UWAIT = 7'h10;
  localparam logic [FLAG_W-1:0] FL_IWAIT = 7'h20;

  // Scan kinds run by the datapath
  typedef enum logic [1:0] {
    SCAN_PROBE,
    SCAN_DIRTY_ALL,
    SCAN_DIRTY_DISK
  } scan_kind_t;

  // Controller to datapath
  typedef struct packed {
    logic       latch;      // capture input item
    logic       scan_start; // clear scan results, index to zero
    logic       scan_step;  // examine one entry
    scan_kind_t kind;
    logic       finish;     // apply update and build result
  } bctc_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_last;
    logic hit_seen;
    logic free_seen;  // probe scan found an idle clean entry
    logic sel_chain;  // selected entry in range and valid
  } bctc_sts_t;

endpackage

>>> rtl/core/block_cache_tag_controller_unit.sv
// Top level of the block cache tag controller.
// Release, unknown ops and io completion without a chained write need no scan; probe and
// flush scan the entries once; acquire scans again to flush every disk when none is free,
// and a chained io completion scans the disk. One item at a time: the next input transfer
// is taken only after the result has been taken; each scan walks one entry a cycle.
// Reset (synchronous, rst_n low) clears entries.
module block_cache_tag_controller_unit #(
  parameter int ENTRY_COUNT = bctc_pkg::ENTRY_COUNT_DEF,
  parameter int BLOCK_BITS  = bctc_pkg::BLOCK_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [bctc_pkg::OP_W-1:0]   in_operation,
  input  logic [bctc_pkg::DISK_W-1:0] in_disk_id,
  input  logic                        in_any_disk,
  input  logic [BLOCK_BITS-1:0]       in_block_number,
  input  logic                        in_data_flag,
  input  logic [bctc_pkg::SEL_W-1:0]  in_entry_select,
  input  logic                        in_disk_idle,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [bctc_pkg::ST_W-1:0]   out_status,
  output logic                        out_was_hit,
  output logic [bctc_pkg::SEL_W-1:0]  out_entry_found,
  output logic                        out_io_start,
  output logic [bctc_pkg::SEL_W-1:0]  out_io_entry,
  output logic                        out_io_is_write,
  output logic                        out_wake_waiters
);

  bctc_pkg::bctc_cmd_t cmd;
  bctc_pkg::bctc_sts_t sts;

  bctc_datapath #(.ENTRY_COUNT(ENTRY_COUNT), .BLOCK_BITS(BLOCK_BITS)) u_dp (
    .clk, .rst_n, .cmd, .sts,
    .in_operation, .in_disk_id, .in_block_number,
    .in_data_flag, .in_entry_select,
    .res_status(out_status), .res_was_hit(out_was_hit),
    .res_entry_found(out_entry_found), .res_io_start(out_io_start),
    .res_io_entry(out_io_entry), .res_io_is_write(out_io_is_write),
    .res_wake_waiters(out_wake_waiters)
  );

  bctc_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .in_operation, .in_any_disk,
    .in_disk_idle, .out_valid, .out_ready, .cmd, .sts
  );

`ifndef NO_ASSERTIONS
  a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("ready while result held");
  a_io_write: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_io_start && out_status == bctc_pkg::ST_NODIRTY) |-> 1'b0)
    else $error("io started on empty flush");
  a_hit_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_was_hit) |-> !out_io_start) else $error("hit issued read");
`endif

endmodule

>>> rtl/core/bctc_datapath.sv
// Entry store, scan unit and result builder of the block cache tag controller.
module bctc_datapath #(
  parameter int ENTRY_COUNT = bctc_pkg::ENTRY_COUNT_DEF,
  parameter int BLOCK_BITS  = bctc_pkg::BLOCK_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  bctc_pkg::bctc_cmd_t          cmd,
  output bctc_pkg::bctc_sts_t          sts,
  input  logic [bctc_pkg::OP_W-1:0]    in_operation,
  input  logic [bctc_pkg::DISK_W-1:0]  in_disk_id,
  input  logic [BLOCK_BITS-1:0]        in_block_number,
  input  logic                         in_data_flag,
  input  logic [bctc_pkg::SEL_W-1:0]   in_entry_select,
  output logic [bctc_pkg::ST_W-1:0]    res_status,
  output logic                         res_was_hit,
  output logic [bctc_pkg::SEL_W-1:0]   res_entry_found,
  output logic                         res_io_start,
  output logic [bctc_pkg::SEL_W-1:0]   res_io_entry,
  output logic                         res_io_is_write,
  output logic                         res_wake_waiters
);

  localparam int IDX_W = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
  localparam int AW    = bctc_pkg::AGE_W;
  localparam int FW    = bctc_pkg::FLAG_W;
  localparam int SW    = bctc_pkg::SEL_W;

  // Entry state held in flip-flops, set by the synchronous reset
  logic [ENTRY_COUNT-1:0]       valid_r;
  logic [bctc_pkg::DISK_W-1:0]  disk_r  [ENTRY_COUNT];
  logic [BLOCK_BITS-1:0]        block_r [ENTRY_COUNT];
  logic [AW-1:0]                age_r   [ENTRY_COUNT];
  logic [FW-1:0]                flags_r [ENTRY_COUNT];
  logic [AW-1:0]                age_ctr_r;

  // Latched item
  logic [bctc_pkg::OP_W-1:0]    op_r;
  logic [bctc_pkg::DISK_W-1:0]  disk_q_r;
  logic [BLOCK_BITS-1:0]        bn_r;
  logic                         flag_r;
  logic [SW-1:0]                sel_r;

  // Scan state
  logic [IDX_W-1:0]             idx_r;
  logic                         hit_r;
  logic [IDX_W-1:0]             hit_idx_r;
  logic                         best_v_r;
  logic [IDX_W-1:0]             best_idx_r;
  logic [AW-1:0]                best_age_r;
  logic [bctc_pkg::DISK_W-1:0]  scan_disk_r;

  logic        cur_match, cur_free, cur_dirty, cur_older;
  logic [AW-1:0] cur_age;
  logic        sel_in_range;
  logic [IDX_W-1:0] sel_idx;

  assign cur_age   = age_r[idx_r];
  assign cur_older = !best_v_r ||
    ($signed(cur_age) < $signed(best_age_r));
  assign cur_match = valid_r[idx_r] && disk_r[idx_r] == disk_q_r &&
                     block_r[idx_r] == bn_r;
  assign cur_free  = flags_r[idx_r] == '0;
  assign cur_dirty = valid_r[idx_r] && flags_r[idx_r] == bctc_pkg::FL_DIRTY &&
    (cmd.kind == bctc_pkg::SCAN_DIRTY_ALL || disk_r[idx_r] == scan_disk_r);

  assign sel_in_range = {{(32-SW){1'b0}}, sel_r} < ENTRY_COUNT;
  assign sel_idx      = IDX_W'(sel_r);

  assign sts.scan_last = idx_r == IDX_W'(ENTRY_COUNT - 1);
  assign sts.hit_seen  = hit_r;
  assign sts.free_seen = best_v_r;
  assign sts.sel_chain = sel_in_range && valid_r[sel_idx];

  // Latch item, step scan, commit update
  always_ff @(posedge clk) begin
    logic [FW-1:0] f;
    logic [IDX_W-1:0] e;
    logic [bctc_pkg::ST_W-1:0] st;
    logic hv, ios, iow, wk;
    logic [SW-1:0] fnd, ioe;
    f = '0;
    e = '0;
    st = bctc_pkg::ST_OK;
    hv = 1'b0; ios = 1'b0; iow = 1'b0; wk = 1'b0;
    fnd = '0; ioe = '0;
    if (!rst_n) begin
      valid_r   <= '0;
      age_ctr_r <= '0;
      for (int i = 0; i < ENTRY_COUNT; i++) begin
        disk_r[i]  <= '0;
        block_r[i] <= '0;
        age_r[i]   <= AW'(0) - AW'(i);
        flags_r[i] <= '0;
      end
    end else begin
      if (cmd.latch) begin
        op_r     <= in_operation;
        disk_q_r <= in_disk_id;
        bn_r     <= in_block_number;
        flag_r   <= in_data_flag;
        sel_r    <= in_entry_select;
      end
      if (cmd.scan_start) begin
        idx_r    <= '0;
        best_v_r <= 1'b0;
        scan_disk_r <= (op_r == bctc_pkg::OP_IODONE) ? disk_r[sel_idx] : disk_q_r;
        if (op_r != bctc_pkg::OP_IODONE) begin
          hit_r <= 1'b0;
        end else if (cmd.kind == bctc_pkg::SCAN_PROBE) begin
          // Io completion clears flags before the disk scan; wake noted in hit_r
          hit_r <= sel_in_range && (flags_r[sel_idx] & bctc_pkg::FL_IWAIT) != '0;
          if (sel_in_range) begin
            flags_r[sel_idx] <= flags_r[sel_idx] & ~(bctc_pkg::FL_RBUSY |
              bctc_pkg::FL_WBUSY | bctc_pkg::FL_DIRTY | bctc_pkg::FL_IWAIT);
          end
        end
      end
      if (cmd.scan_step) begin
        if (!sts.scan_last) idx_r <= idx_r + 1'b1;
        if (cmd.kind == bctc_pkg::SCAN_PROBE) begin
          if (!hit_r && cur_match) begin
            hit_r     <= 1'b1;
            hit_idx_r <= idx_r;
          end else if (!hit_r && cur_free && cur_older) begin
            best_v_r   <= 1'b1;
            best_idx_r <= idx_r;
            best_age_r <= cur_age;
          end
        end else if (cur_dirty && cur_older) begin
          best_v_r   <= 1'b1;
          best_idx_r <= idx_r;
          best_age_r <= cur_age;
        end
      end
      if (cmd.finish) begin
        case (op_r)
          bctc_pkg::OP_PROBE, bctc_pkg::OP_ACQUIRE: begin
            if (cmd.kind != bctc_pkg::SCAN_PROBE) begin
              // no free entry; acquire tried a flush of every disk
              st = bctc_pkg::ST_NOFREE;
              if (best_v_r) begin
                flags_r[best_idx_r] <= flags_r[best_idx_r] |
                  bctc_pkg::FL_WBUSY | bctc_pkg::FL_IWAIT;
                ios = 1'b1; ioe = SW'(best_idx_r); iow = 1'b1;
              end
            end else if (!hit_r && !best_v_r) begin
              st = bctc_pkg::ST_NOFREE;
            end else begin
              if (hit_r) begin
                e = hit_idx_r;
                f = flags_r[e];
                if ((f & (bctc_pkg::FL_ULOCK | bctc_pkg::FL_RBUSY |
                          bctc_pkg::FL_WBUSY)) == '0) begin
                  age_r[e]  <= age_ctr_r;
                  age_ctr_r <= age_ctr_r + 1'b1;
                end
                hv = 1'b1;
              end else begin
                e = best_idx_r;
                f = flags_r[e];
                valid_r[e] <= 1'b1;
                disk_r[e]  <= disk_q_r;
                block_r[e] <= bn_r;
                age_r[e]   <= age_ctr_r;
                age_ctr_r  <= age_ctr_r + 1'b1;
                if (flag_r) begin
                  f = bctc_pkg::FL_RBUSY;
                  ios = 1'b1; ioe = SW'(e);
                end
              end
              fnd = SW'(e);
              if (op_r == bctc_pkg::OP_ACQUIRE) begin
                if ((f & bctc_pkg::FL_ULOCK) != '0) begin
                  f = f | bctc_pkg::FL_UWAIT;
                  st = bctc_pkg::ST_LOCKED;
                end else if ((f & (bctc_pkg::FL_RBUSY | bctc_pkg::FL_WBUSY)) != '0) begin
                  f = f | bctc_pkg::FL_IWAIT;
                  st = bctc_pkg::ST_IOBUSY;
                end else begin
                  f = f | bctc_pkg::FL_ULOCK;
                end
              end
              flags_r[e] <= f;
            end
          end
          bctc_pkg::OP_RELEASE: begin
            if (!sel_in_range || (flags_r[sel_idx] & bctc_pkg::FL_ULOCK) == '0) begin
              st = bctc_pkg::ST_UNLOCKED;
            end else begin
              f = flags_r[sel_idx];
              if (flag_r) f = f | bctc_pkg::FL_DIRTY;
              if ((f & bctc_pkg::FL_UWAIT) != '0) wk = 1'b1;
              flags_r[sel_idx] <= f & ~(bctc_pkg::FL_UWAIT | bctc_pkg::FL_ULOCK);
            end
          end
          bctc_pkg::OP_FLUSH: begin
            if (!best_v_r) begin
              st = bctc_pkg::ST_NODIRTY;
            end else begin
              flags_r[best_idx_r] <= flags_r[best_idx_r] |
                bctc_pkg::FL_WBUSY | bctc_pkg::FL_IWAIT;
              ios = 1'b1; ioe = SW'(best_idx_r); iow = 1'b1;
            end
          end
          bctc_pkg::OP_IODONE: begin
            if (sel_in_range) begin
              // completion clear was applied before the disk scan
              if (cmd.kind == bctc_pkg::SCAN_DIRTY_DISK && best_v_r) begin
                flags_r[best_idx_r] <= flags_r[best_idx_r] | bctc_pkg::FL_WBUSY;
                ios = 1'b1; ioe = SW'(best_idx_r); iow = 1'b1;
              end
              wk = hit_r;
            end
          end
          default: ;
        endcase
        res_status       <= st;
        res_was_hit      <= hv;
        res_entry_found  <= fnd;
        res_io_start     <= ios;
        res_io_entry     <= ioe;
        res_io_is_write  <= iow;
        res_wake_waiters <= wk;
      end
    end
  end

endmodule

>>> rtl/core/bctc_ctrl.sv
// Sequencing state machine of the block cache tag controller.
module bctc_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [bctc_pkg::OP_W-1:0]   in_operation,
  input  logic                        in_any_disk,
  input  logic                        in_disk_idle,
  output logic                        out_valid,
  input  logic                        out_ready,
  output bctc_pkg::bctc_cmd_t         cmd,
  input  bctc_pkg::bctc_sts_t         sts
);

  typedef enum logic [2:0] {
    S_IDLE, S_START, S_SCAN, S_CHECK, S_START2, S_SCAN2, S_FINISH, S_OUT
  } state_t;

  state_t state_r;
  logic [bctc_pkg::OP_W-1:0] op_r;
  logic idle_r;
  bctc_pkg::scan_kind_t kind_r;
  logic out_valid_r;

  assign in_ready  = state_r == S_IDLE && !out_valid_r;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd = '0;
    cmd.kind = kind_r;
    cmd.latch = in_valid && in_ready;
    cmd.scan_start = state_r == S_START || state_r == S_START2;
    cmd.scan_step  = state_r == S_SCAN || state_r == S_SCAN2;
    cmd.finish     = state_r == S_FINISH;
  end

  // Advance through latch, scans and result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      kind_r      <= bctc_pkg::SCAN_PROBE;
      op_r        <= '0;
      idle_r      <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: if (cmd.latch) begin
          op_r <= in_operation; idle_r <= in_disk_idle;
          state_r <= S_START;
          kind_r <= (in_operation == bctc_pkg::OP_FLUSH) ?
            (in_any_disk ? bctc_pkg::SCAN_DIRTY_ALL : bctc_pkg::SCAN_DIRTY_DISK) :
            bctc_pkg::SCAN_PROBE;
        end
        S_START: begin
          if (op_r == bctc_pkg::OP_IODONE) begin
            state_r <= (idle_r && sts.sel_chain) ? S_START2 : S_FINISH;
            kind_r  <= bctc_pkg::SCAN_DIRTY_DISK;
          end else if (op_r == bctc_pkg::OP_RELEASE || op_r > bctc_pkg::OP_IODONE) begin
            state_r <= S_FINISH;
          end else begin
            state_r <= S_SCAN;
          end
        end
        S_SCAN: if (sts.scan_last) begin
          if (op_r == bctc_pkg::OP_ACQUIRE && kind_r == bctc_pkg::SCAN_PROBE) begin
            state_r <= S_CHECK;
          end else begin
            state_r <= S_FINISH;
          end
        end
        // Acquire with no hit and no free entry goes on to flush every disk
        S_CHECK: begin
          if (!sts.hit_seen && !sts.free_seen) begin
            kind_r  <= bctc_pkg::SCAN_DIRTY_ALL;
            state_r <= S_START2;
          end else begin
            state_r <= S_FINISH;
          end
        end
        S_START2: state_r <= S_SCAN2;
        S_SCAN2: if (sts.scan_last) state_r <= S_FINISH;
        S_FINISH: begin state_r <= S_OUT; out_valid_r <= 1'b1; end
        S_OUT: if (out_ready) begin state_r <= S_IDLE; out_valid_r <= 1'b0; end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

>>> test/tb.sv
// Testbench for the block cache tag controller, checked against a predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NENT = 16;
  localparam int BBITS = 24;

  typedef struct packed {
    logic [bctc_pkg::ST_W-1:0]  status;
    logic                       was_hit;
    logic [bctc_pkg::SEL_W-1:0] entry_found;
    logic                       io_start;
    logic [bctc_pkg::SEL_W-1:0] io_entry;
    logic                       io_is_write;
    logic                       wake;
  } result_t;

  // Tag state predictor with a queue of expected results
  class tag_scoreboard;
    bit                          valid_q[NENT];
    bit [bctc_pkg::DISK_W-1:0]   disk_q[NENT];
    bit [BBITS-1:0]              block_q[NENT];
    bit [bctc_pkg::AGE_W-1:0]    age_q[NENT];
    bit [bctc_pkg::FLAG_W-1:0]   flags_q[NENT];
    bit [bctc_pkg::AGE_W-1:0]    age_cnt;
    result_t                     pending[$];
    int                          mismatches;

    function void clear();
      for (int i = 0; i < NENT; i++) begin
        valid_q[i] = 0; disk_q[i] = 0; block_q[i] = 0;
        age_q[i] = 32'(-i); flags_q[i] = 0;
      end
      age_cnt = 0;
    endfunction

    function bit older(bit [bctc_pkg::AGE_W-1:0] a, bit [bctc_pkg::AGE_W-1:0] b);
      return $signed(a) < $signed(b);
    endfunction

    function bit [bctc_pkg::AGE_W-1:0] take_age();
      take_age = age_cnt;
      age_cnt++;
    endfunction

    function int oldest_dirty(bit every, bit [bctc_pkg::DISK_W-1:0] d);
      int best;
      best = -1;
      for (int i = 0; i < NENT; i++) begin
        if (!valid_q[i] || flags_q[i] != bctc_pkg::FL_DIRTY) continue;
        if (!every && disk_q[i] != d) continue;
        if (best < 0 || older(age_q[i], age_q[best])) best = i;
      end
      return best;
    endfunction

    // Predict the result of one transferred operation
    function void note_input(bit [bctc_pkg::OP_W-1:0] op, bit [bctc_pkg::DISK_W-1:0] d,
                             bit every, bit [BBITS-1:0] bn, bit flag,
                             bit [bctc_pkg::SEL_W-1:0] sel, bit idle);
      result_t r;
      int e, w, best;
      bit rd;
      r = '0;
      case (op)
        bctc_pkg::OP_PROBE, bctc_pkg::OP_ACQUIRE: begin
          e = -1; best = -1; rd = 0;
          for (int i = 0; i < NENT; i++) begin
            if (valid_q[i] && disk_q[i] == d && block_q[i] == bn) begin
              if ((flags_q[i] & (bctc_pkg::FL_ULOCK | bctc_pkg::FL_RBUSY |
                                 bctc_pkg::FL_WBUSY)) == 0)
                age_q[i] = take_age();
              r.was_hit = 1;
              e = i;
              break;
            end
            if (flags_q[i] == 0 && (best < 0 || older(age_q[i], age_q[best])))
              best = i;
          end
          if (e < 0 && best >= 0) begin
            e = best;
            valid_q[e] = 1; disk_q[e] = d; block_q[e] = bn;
            age_q[e] = take_age();
            if (flag) begin
              flags_q[e] = bctc_pkg::FL_RBUSY;
              rd = 1;
            end
          end
          if (e < 0) begin
            r.status = bctc_pkg::ST_NOFREE;
            if (op == bctc_pkg::OP_ACQUIRE) begin
              w = oldest_dirty(1'b1, 3'd0);
              if (w >= 0) begin
                flags_q[w] |= bctc_pkg::FL_WBUSY | bctc_pkg::FL_IWAIT;
                r.io_start = 1; r.io_entry = bctc_pkg::SEL_W'(w); r.io_is_write = 1;
              end
            end
          end else begin
            r.entry_found = bctc_pkg::SEL_W'(e);
            if (rd) begin
              r.io_start = 1; r.io_entry = bctc_pkg::SEL_W'(e);
            end
            if (op == bctc_pkg::OP_ACQUIRE) begin
              if (flags_q[e] & bctc_pkg::FL_ULOCK) begin
                flags_q[e] |= bctc_pkg::FL_UWAIT; r.status = bctc_pkg::ST_LOCKED;
              end else if (flags_q[e] & (bctc_pkg::FL_RBUSY | bctc_pkg::FL_WBUSY)) begin
                flags_q[e] |= bctc_pkg::FL_IWAIT; r.status = bctc_pkg::ST_IOBUSY;
              end else flags_q[e] |= bctc_pkg::FL_ULOCK;
            end
          end
        end
        bctc_pkg::OP_RELEASE: begin
          if (!(flags_q[sel] & bctc_pkg::FL_ULOCK)) r.status = bctc_pkg::ST_UNLOCKED;
          else begin
            if (flag) flags_q[sel] |= bctc_pkg::FL_DIRTY;
            if (flags_q[sel] & bctc_pkg::FL_UWAIT) begin
              flags_q[sel] &= ~bctc_pkg::FL_UWAIT; r.wake = 1;
            end
            flags_q[sel] &= ~bctc_pkg::FL_ULOCK;
          end
        end
        bctc_pkg::OP_FLUSH: begin
          w = oldest_dirty(every, d);
          if (w < 0) r.status = bctc_pkg::ST_NODIRTY;
          else begin
            flags_q[w] |= bctc_pkg::FL_WBUSY | bctc_pkg::FL_IWAIT;
            r.io_start = 1; r.io_entry = bctc_pkg::SEL_W'(w); r.io_is_write = 1;
          end
        end
        bctc_pkg::OP_IODONE: begin
          flags_q[sel] &= ~(bctc_pkg::FL_RBUSY | bctc_pkg::FL_WBUSY | bctc_pkg::FL_DIRTY);
          if (flags_q[sel] & bctc_pkg::FL_IWAIT) begin
            flags_q[sel] &= ~bctc_pkg::FL_IWAIT; r.wake = 1;
          end
          if (idle && valid_q[sel]) begin
            w = oldest_dirty(1'b0, disk_q[sel]);
            if (w >= 0) begin
              flags_q[w] |= bctc_pkg::FL_WBUSY;
              r.io_start = 1; r.io_entry = bctc_pkg::SEL_W'(w); r.io_is_write = 1;
            end
          end
        end
        default: ;
      endcase
      pending.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t exp;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      exp = pending.pop_front();
      if (got != exp) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p got %p", exp, got);
      end
    endfunction
  endclass

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, out_ready = 0;
  logic [bctc_pkg::OP_W-1:0] in_operation = '0;
  logic [bctc_pkg::DISK_W-1:0] in_disk_id = '0;
  logic in_any_disk = 0, in_data_flag = 0, in_disk_idle = 0;
  logic [BBITS-1:0] in_block_number = '0;
  logic [bctc_pkg::SEL_W-1:0] in_entry_select = '0;
  logic in_ready, out_valid, out_was_hit, out_io_start, out_io_is_write, out_wake_waiters;
  logic [bctc_pkg::ST_W-1:0] out_status;
  logic [bctc_pkg::SEL_W-1:0] out_entry_found, out_io_entry;

  int send_idle_pct = 17, recv_idle_pct = 64;
  bit hold_req = 0;
  logic hold_on = 0;
  tag_scoreboard sb;

  block_cache_tag_controller_unit dut (.*);

  initial forever #10 clk = ~clk;

  initial begin
    #50ms;
    $display("tb: FAIL");
    $finish;
  end

  // Hold off the receiver for a long stretch once requested
  initial begin
    wait (hold_req);
    @(posedge clk);
    hold_on <= 1'b1;
    repeat (400) @(posedge clk);
    hold_on <= 1'b0;
  end

  // Receiver: random stalls plus the long hold-off
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result('{out_status, out_was_hit, out_entry_found, out_io_start,
                        out_io_entry, out_io_is_write, out_wake_waiters});
    if (hold_on) out_ready <= 0;
    else out_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  // Offer one item and hold it until transferred
  task automatic send_op(bit [bctc_pkg::OP_W-1:0] op, bit [bctc_pkg::DISK_W-1:0] d,
                         bit every, bit [BBITS-1:0] bn, bit flag,
                         bit [bctc_pkg::SEL_W-1:0] sel, bit idle);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1; in_operation <= op; in_disk_id <= d; in_any_disk <= every;
    in_block_number <= bn; in_data_flag <= flag; in_entry_select <= sel;
    in_disk_idle <= idle;
    do @(posedge clk); while (!in_ready);
    sb.note_input(op, d, every, bn, flag, sel, idle);
  endtask

  // Mostly reuse a small block pool so hits and evictions occur
  task automatic random_op();
    bit [bctc_pkg::OP_W-1:0] op;
    bit [BBITS-1:0] bn;
    int k;
    k = $urandom_range(99);
    op = k < 30 ? bctc_pkg::OP_PROBE : k < 55 ? bctc_pkg::OP_ACQUIRE :
         k < 75 ? bctc_pkg::OP_RELEASE : k < 85 ? bctc_pkg::OP_FLUSH :
         k < 98 ? bctc_pkg::OP_IODONE : 3'($urandom_range(7, 5));
    bn = ($urandom_range(9) == 0) ? BBITS'($urandom) : BBITS'($urandom_range(23));
    send_op(op, ($urandom_range(3) == 0) ? 3'($urandom) : 3'($urandom_range(1)),
            1'($urandom_range(1)), bn, 1'($urandom_range(1)),
            bctc_pkg::SEL_W'($urandom), 1'($urandom_range(1)));
  endtask

  initial begin
    int wd;
    sb = new();
    sb.clear();
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // Directed: empty flush, releases of unlocked, unknown ops, field extremes, probes, acquires, io completions
    send_op(bctc_pkg::OP_FLUSH, 3'd0, 1'b1, BBITS'(0), 1'b0, 4'd0, 1'b0);
    send_op(bctc_pkg::OP_RELEASE, 3'd0, 1'b0, BBITS'(0), 1'b1, 4'd15, 1'b0);
    send_op(bctc_pkg::OP_IODONE, 3'd7, 1'b0, BBITS'(0), 1'b0, 4'd15, 1'b1);
    send_op(3'd5, 3'd7, 1'b1, '1, 1'b1, 4'd15, 1'b1);
    send_op(3'd7, 3'd0, 1'b0, BBITS'(0), 1'b0, 4'd0, 1'b0);
    send_op(bctc_pkg::OP_PROBE, 3'd7, 1'b0, '1, 1'b0, 4'd0, 1'b0);
    send_op(bctc_pkg::OP_PROBE, 3'd7, 1'b0, '1, 1'b1, 4'd0, 1'b0);
    send_op(bctc_pkg::OP_ACQUIRE, 3'd0, 1'b0, BBITS'(0), 1'b1, 4'd0, 1'b0);
    send_op(bctc_pkg::OP_ACQUIRE, 3'd0, 1'b0, BBITS'(0), 1'b1, 4'd0, 1'b0);
    send_op(bctc_pkg::OP_IODONE, 3'd0, 1'b0, BBITS'(0), 1'b0, 4'd1, 1'b1);
    send_op(bctc_pkg::OP_ACQUIRE, 3'd0, 1'b0, BBITS'(0), 1'b0, 4'd0, 1'b0);
    send_op(bctc_pkg::OP_ACQUIRE, 3'd0, 1'b0, BBITS'(0), 1'b0, 4'd0, 1'b0);
    send_op(bctc_pkg::OP_RELEASE, 3'd0, 1'b0, BBITS'(0), 1'b1, 4'd1, 1'b0);
    send_op(bctc_pkg::OP_FLUSH, 3'd0, 1'b0, BBITS'(0), 1'b0, 4'd0, 1'b0);
    send_op(bctc_pkg::OP_IODONE, 3'd0, 1'b0, BBITS'(0), 1'b0, 4'd1, 1'b1);
    // Fill every entry with locked blocks, then acquire with none free
    for (int i = 0; i < NENT; i++)
      send_op(bctc_pkg::OP_ACQUIRE, 3'(i), 1'b0, BBITS'(i + 100), 1'b0, 4'd0, 1'b0);
    send_op(bctc_pkg::OP_RELEASE, 3'd0, 1'b0, BBITS'(0), 1'b1, 4'd2, 1'b0);
    send_op(bctc_pkg::OP_ACQUIRE, 3'd5, 1'b0, BBITS'(999), 1'b1, 4'd0, 1'b0);
    send_op(bctc_pkg::OP_PROBE, 3'd5, 1'b0, BBITS'(998), 1'b0, 4'd0, 1'b0);
    // Random phases with three idling profiles; long receiver hold-off in first
    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin send_idle_pct = 64; recv_idle_pct = 17; end
      if (ph == 2) begin send_idle_pct = 0; recv_idle_pct = 0; end
      for (int n = 0; n < 500; n++) begin
        if (ph == 0 && n == 100) hold_req = 1;
        random_op();
        // Periodically drain locks and io to keep the cache moving
        if (n % 150 == 149)
          for (int i = 0; i < NENT; i++) begin
            send_op(bctc_pkg::OP_RELEASE, 3'd0, 1'b0, BBITS'(0), 1'($urandom_range(1)),
                    bctc_pkg::SEL_W'(i), 1'b0);
            send_op(bctc_pkg::OP_IODONE, 3'd0, 1'b0, BBITS'(0), 1'b0,
                    bctc_pkg::SEL_W'(i), 1'($urandom_range(1)));
          end
      end
    end
    in_valid <= 0;
    wd = 0;
    while (sb.pending.size() != 0 && wd < 200000) begin
      @(posedge clk);
      wd++;
    end
    repeat (100) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end
endmodule
